// ----- src/vst_pkg.sv -----
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types, sizes and helpers for the vertex split by tangent unit.
// ----------------------------------------------------------------------------
package vst_pkg;

  // Table sizes
  localparam int unsigned MaxVertices    = 4096;
  localparam int unsigned SlotsPerVertex = 4;
  localparam int unsigned MaxOutVertices = 16384;

  localparam int unsigned VtxW   = 12;                          // vertex_index width
  localparam int unsigned AddrW  = $clog2(MaxVertices);         // row address width
  localparam int unsigned SlotW  = (SlotsPerVertex > 1) ? $clog2(SlotsPerVertex) : 1;
  localparam int unsigned FillW  = $clog2(SlotsPerVertex + 1);  // holds 0..SlotsPerVertex
  localparam int unsigned IdxW   = 14;                          // new_index width
  localparam int unsigned NextW  = $clog2(MaxOutVertices) + 1;  // duplicate counter width
  localparam int unsigned CountW = 13;                          // vertex_count width

  typedef enum logic [1:0] {
    StReused   = 2'd0,
    StFirst    = 2'd1,
    StDup      = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CtlClear,
    CtlIdle,
    CtlEval
  } ctl_state_e;

  typedef struct packed {
    logic            start_mesh;
    logic [VtxW-1:0] vertex_index;
    logic [31:0]     tangent_x;
    logic [31:0]     tangent_y;
    logic [31:0]     tangent_z;
    logic [31:0]     tangent_sign;
  } corner_t;

  typedef struct packed {
    logic [IdxW-1:0] new_index;
    status_e         status;
  } result_t;

  // One stored tangent and the index bound to it
  typedef struct packed {
    logic [31:0]     tan_x;
    logic [31:0]     tan_y;
    logic [31:0]     tan_z;
    logic [31:0]     tan_w;
    logic [IdxW-1:0] target;
  } slot_t;

  // One memory row: everything kept for one original vertex
  typedef struct packed {
    logic [FillW-1:0]               fill;
    slot_t [SlotsPerVertex-1:0]     slots;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;      // capture the incoming corner
    logic             load_next;   // reload duplicate counter from vertex_count
    logic             clear;       // zero the row at clear_addr
    logic [AddrW-1:0] clear_addr;
    logic             eval;        // resolve the captured corner
    logic             fresh;       // table just cleared: treat the row as empty
  } ctl_cmd_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:0] > 31'h7F80_0000);
  endfunction

  // IEEE equality on single bit patterns: +0 == -0, NaN never equal
  function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] both;
    both = a | b;
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    return (a == b) || (both[30:0] == 31'd0);
  endfunction

endpackage

// ----- src/vst_ctrl.sv -----
// ----------------------------------------------------------------------------
// vst_ctrl
// Sequencer: table clear sweep, corner capture and evaluation.
// ----------------------------------------------------------------------------
module vst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              start_mesh_i,
  output logic              busy,
  output vst_pkg::ctl_cmd_t cmd_o
);
  import vst_pkg::*;

  ctl_state_e       state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic             accept;

  assign accept = start && (state_q == CtlIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    unique case (state_q)
      CtlClear: begin
        cnt_d = cnt_q + AddrW'(1);
        if (cnt_q == AddrW'(MaxVertices - 1)) begin
          state_d = pend_q ? CtlEval : CtlIdle;
        end
      end
      CtlIdle: begin
        if (accept) begin
          pend_d = start_mesh_i;
          cnt_d  = '0;
          state_d = start_mesh_i ? CtlClear : CtlEval;
        end
      end
      CtlEval: begin
        state_d = CtlIdle;
      end
      default: begin
        state_d = CtlIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.load_next  = accept && start_mesh_i;
    cmd_o.clear      = (state_q == CtlClear);
    cmd_o.clear_addr = cnt_q;
    cmd_o.eval       = (state_q == CtlEval);
    cmd_o.fresh      = pend_q;
  end

  assign busy = (state_q != CtlIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlClear;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ----- src/vst_datapath.sv -----
// ----------------------------------------------------------------------------
// vst_datapath
// Slot row memory, tangent compare, slot allocation and result register.
// ----------------------------------------------------------------------------
module vst_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [12:0]         cfg_wdata_i,
  input  vst_pkg::corner_t    corner_i,
  input  vst_pkg::ctl_cmd_t   cmd_i,
  output logic                result_valid_o,
  output vst_pkg::result_t    result_o
);
  import vst_pkg::*;

  row_t             mem [MaxVertices];
  row_t             rdata_q;
  corner_t          corner_q;
  logic [CountW-1:0] vcount_q;
  logic [NextW-1:0] next_q, next_d;
  logic             rvalid_q;
  result_t          res_q, res_d;

  logic [FillW-1:0]          fill;
  logic [SlotsPerVertex-1:0] hit;
  logic                      any_hit;
  logic [IdxW-1:0]           hit_target;
  logic                      do_alloc;
  logic [IdxW-1:0]           alloc_target;
  row_t                      wrow;
  slot_t                     nslot;
  logic                      we;
  logic [AddrW-1:0]          waddr;
  row_t                      wdata;

  // Compare every slot in parallel; first hit wins
  always_comb begin
    fill = cmd_i.fresh ? '0 : rdata_q.fill;
    for (int k = 0; k < SlotsPerVertex; k++) begin
      hit[k] = (FillW'(k) < fill)
            && f_eq(rdata_q.slots[k].tan_x, corner_q.tangent_x)
            && f_eq(rdata_q.slots[k].tan_y, corner_q.tangent_y)
            && f_eq(rdata_q.slots[k].tan_z, corner_q.tangent_z)
            && f_eq(rdata_q.slots[k].tan_w, corner_q.tangent_sign);
    end
    any_hit    = |hit;
    hit_target = '0;
    for (int k = SlotsPerVertex - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_target = rdata_q.slots[k].target;
      end
    end
  end

  // Resolve the corner
  always_comb begin
    res_d        = '0;
    next_d       = next_q;
    do_alloc     = 1'b0;
    alloc_target = '0;
    priority if (any_hit) begin
      res_d.new_index = hit_target;
      res_d.status    = StReused;
    end else if (fill >= FillW'(SlotsPerVertex)) begin
      res_d.status    = StOverflow;
    end else if (fill == '0) begin
      do_alloc        = 1'b1;
      alloc_target    = IdxW'(corner_q.vertex_index);
      res_d.new_index = alloc_target;
      res_d.status    = StFirst;
    end else if (next_q >= NextW'(MaxOutVertices)) begin
      res_d.status    = StOverflow;
    end else begin
      do_alloc        = 1'b1;
      alloc_target    = next_q[IdxW-1:0];
      res_d.new_index = alloc_target;
      res_d.status    = StDup;
      if (cmd_i.eval) begin
        next_d = next_q + NextW'(1);
      end
    end
    if (cmd_i.load_next) begin
      next_d = NextW'(vcount_q);
    end
  end

  // Build the updated row and pick the write source
  always_comb begin
    nslot.tan_x  = corner_q.tangent_x;
    nslot.tan_y  = corner_q.tangent_y;
    nslot.tan_z  = corner_q.tangent_z;
    nslot.tan_w  = corner_q.tangent_sign;
    nslot.target = alloc_target;
    wrow         = rdata_q;
    wrow.fill    = fill + FillW'(1);
    wrow.slots[fill[SlotW-1:0]] = nslot;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = cmd_i.clear_addr;
      wdata = '0;
    end else begin
      we    = cmd_i.eval && do_alloc;
      waddr = corner_q.vertex_index[AddrW-1:0];
      wdata = wrow;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[corner_i.vertex_index[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      corner_q <= corner_i;
    end
    if (cmd_i.eval) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      next_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      next_q   <= next_d;
      rvalid_q <= cmd_i.eval;
    end
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

endmodule

// ----- src/vertex_split_by_tangent_unit.sv -----
// ----------------------------------------------------------------------------
// vertex_split_by_tangent_unit
// Assigns output vertex indices to triangle corners, splitting vertices whose
// corners carry different tangents.
// ----------------------------------------------------------------------------
// Usage: a corner beat is taken on a clock edge with start high and busy low,
// and its result is shown on result_o for exactly one cycle with
// result_valid_o high; the receiver cannot stall, so sample it then. A plain
// corner has its row read on the accept edge and is compared and written back
// in the next cycle, and its result appears in the cycle after the evaluation.
// A corner with start_mesh set first sweeps the whole slot table, one row
// per cycle, and only then moves on to its evaluation.
// The same sweep runs right after reset with busy high; no corner
// is taken until it ends, while vertex_count writes are taken at any time.
// Write vertex_count only while the unit is idle.
// ----------------------------------------------------------------------------
module vertex_split_by_tangent_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: vertex_count
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_wdata_i,
  // corner beats
  input  logic             start,
  output logic             busy,
  input  vst_pkg::corner_t corner_i,
  // result beats
  output logic             result_valid_o,
  output vst_pkg::result_t result_o
);
  import vst_pkg::*;

  ctl_cmd_t cmd;

  // Sequencer: clear sweep, capture, evaluate
  vst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .start_mesh_i(corner_i.start_mesh),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // Slot memory, compare and allocation
  vst_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .corner_i      (corner_i),
    .cmd_i         (cmd),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// ----- verif/vertex_split_by_tangent_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_split_by_tangent_unit_test
// Self-checking bench for the vertex split by tangent unit. A driver feeds
// corner beats from a backlog, a predictor resolves each accepted corner
// against its own slot table, and a monitor checks every result beat against
// the oldest predicted index and status.
// ----------------------------------------------------------------------------
module vertex_split_by_tangent_unit_test;
  import vst_pkg::*;

  localparam int unsigned SlotTotal   = MaxVertices * SlotsPerVertex;
  localparam int unsigned PaletteSize = 6;
  localparam int unsigned PoolSize    = 6;
  localparam int unsigned IdlePct     = 29;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              start       = 1'b0;
  logic              busy;
  corner_t           corner_i    = '0;
  logic              result_valid_o;
  result_t           result_o;

  vertex_split_by_tangent_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .corner_i       (corner_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #5ns clk_i = ~clk_i;

  // Predictor state: the bench's own copy of the slot table and counters.
  int unsigned mesh_vertex_count = 0;
  int unsigned dup_next          = 0;
  int unsigned row_fill [MaxVertices];
  slot_t       slot_mem [SlotTotal];

  corner_t     corner_backlog [$];  // corners waiting to be offered
  result_t     index_forecast [$];  // predicted results, oldest first
  int unsigned corners_queued = 0;
  int unsigned results_taken  = 0;
  int unsigned fault_count    = 0;
  bit          steady         = 1'b0;  // suppress sender gaps for a whole phase
  bit          offer_next;
  result_t     want;

  // Stimulus material: a small tangent palette and vertex pool, so that rows
  // fill up and tangents come back for reuse.
  logic [3:0][31:0] palette [PaletteSize];
  logic [VtxW-1:0]  pool    [PoolSize];

  // IEEE single equality on bit patterns: signed zeros are equal, NaN is
  // equal to nothing, itself included.
  function automatic bit float_eq(logic [31:0] a, logic [31:0] b);
    bit a_nan, b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    return (a == b) || ((a[30:0] == '0) && (b[30:0] == '0));
  endfunction

  // Resolve one accepted corner: look for a matching tangent in the vertex's
  // row, else bind the tangent to the vertex itself or to a fresh duplicate.
  function automatic result_t resolve_corner(corner_t c);
    result_t     r;
    slot_t       s;
    int unsigned v, fill, base;
    if (c.start_mesh) begin
      foreach (row_fill[i]) begin
        row_fill[i] = 0;
      end
      dup_next = mesh_vertex_count;
    end
    r.new_index = '0;
    r.status    = StOverflow;
    v = 32'(c.vertex_index);
    if (v >= MaxVertices) begin
      return r;
    end
    fill = row_fill[v];
    base = v * SlotsPerVertex;
    for (int unsigned k = 0; k < fill; k++) begin
      s = slot_mem[base + k];
      if (float_eq(s.tan_x, c.tangent_x) && float_eq(s.tan_y, c.tangent_y) &&
          float_eq(s.tan_z, c.tangent_z) && float_eq(s.tan_w, c.tangent_sign)) begin
        r.new_index = s.target;
        r.status    = StReused;
        return r;
      end
    end
    // A full row or a dry duplicate counter reports overflow and leaves the
    // table untouched.
    if (fill >= SlotsPerVertex) begin
      return r;
    end
    if ((fill != 0) && (dup_next >= MaxOutVertices)) begin
      return r;
    end
    if (fill == 0) begin
      s.target = IdxW'(v);
      r.status = StFirst;
    end else begin
      s.target = IdxW'(dup_next);
      r.status = StDup;
      dup_next++;
    end
    s.tan_x = c.tangent_x;
    s.tan_y = c.tangent_y;
    s.tan_z = c.tangent_z;
    s.tan_w = c.tangent_sign;
    slot_mem[base + fill] = s;
    row_fill[v] = fill + 1;
    r.new_index = s.target;
    return r;
  endfunction

  function automatic logic [3:0][31:0] tan4(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [31:0] w);
    return {w, z, y, x};
  endfunction

  task automatic queue_corner(bit mesh, int unsigned v, logic [3:0][31:0] t);
    corner_t c;
    c.start_mesh   = mesh;
    c.vertex_index = VtxW'(v);
    c.tangent_x    = t[0];
    c.tangent_y    = t[1];
    c.tangent_z    = t[2];
    c.tangent_sign = t[3];
    corner_backlog.insert(corner_backlog.size(), c);
    corners_queued++;
  endtask

  // Write vertex_count; callers drain the sender first, except the first call during the reset sweep.
  task automatic write_vertex_count(logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mesh_vertex_count = 32'(value);
  endtask

  // Hold until every queued corner has produced its result beat.
  task automatic wait_drained();
    while (results_taken != corners_queued) begin
      @(posedge clk_i);
    end
  endtask

  // Random corners drawn mostly from a small palette and vertex pool, so rows
  // see reuse, duplicates and full-row overflow; the rest is pure noise.
  task automatic run_mixed(int unsigned n);
    logic [3:0][31:0] t;
    int unsigned      v;
    bit               mesh;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        foreach (pool[p]) begin
          pool[p] = VtxW'($urandom_range(MaxVertices - 1));
        end
        if ($urandom_range(3) == 0) begin
          pool[0] = '0;
          pool[1] = '1;
        end
        foreach (palette[p]) begin
          palette[p] = {$urandom, $urandom, $urandom, $urandom};
        end
        // Plant signed zeros and infinities in fixed palette spots, and a NaN in a random component of one entry.
        palette[1][1] = '0;
        palette[1][3] = 32'h8000_0000;
        palette[2][$urandom_range(3)] = {1'($urandom_range(1)), 8'hFF,
                                         23'($urandom_range(23'h7F_FFFF, 1))};
        palette[3][0] = 32'h7F80_0000;
        palette[3][2] = 32'hFF80_0000;
      end
      mesh = (i == 0) || ($urandom_range(99) == 0);
      if ($urandom_range(99) < 85) begin
        t = palette[$urandom_range(PaletteSize - 1)];
        // Flip the sign of zero components: the match must not care.
        for (int c = 0; c < 4; c++) begin
          if (t[c][30:0] == '0) begin
            t[c][31] = 1'($urandom_range(1));
          end
        end
      end else begin
        t = {$urandom, $urandom, $urandom, $urandom};
      end
      if ($urandom_range(99) < 85) begin
        v = 32'(pool[$urandom_range(PoolSize - 1)]);
      end else begin
        v = $urandom_range(MaxVertices - 1);
      end
      queue_corner(mesh, v, t);
    end
  endtask

  // Driver: hold an offered beat until busy drops, predict it on the accepting
  // edge, then offer the next backlog entry unless a random gap comes up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      offer_next = start && busy;
      if (start && !busy) begin
        index_forecast.insert(index_forecast.size(), resolve_corner(corner_i));
      end
      if (!offer_next && (corner_backlog.size() != 0) &&
          (steady || ($urandom_range(99) >= IdlePct))) begin
        corner_i   <= corner_backlog.pop_front();
        offer_next  = 1'b1;
      end
      start <= offer_next;
    end
  end

  // Monitor: a result beat lives for one cycle only, so take it on every edge
  // that sees the strobe and compare against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_taken++;
      if (index_forecast.size() == 0) begin
        $error("result beat with nothing predicted: new_index %0d, status %0d",
               result_o.new_index, result_o.status);
        fault_count++;
      end else begin
        want = index_forecast.pop_front();
        if (result_o.new_index !== want.new_index) begin
          $error("new_index mismatch: expected %0d, got %0d",
                 want.new_index, result_o.new_index);
          fault_count++;
        end
        if (result_o.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, result_o.status);
          fault_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: signed zeros, NaNs, infinities, full rows, table
    // clear with counter reload, and both extremes of the vertex index.
    write_vertex_count(13'd4096);
    queue_corner(1'b1, 0, tan4(32'h0, 32'h0, 32'h0, 32'h0));
    queue_corner(1'b0, 0, tan4(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h8000_0000));
    queue_corner(1'b0, 0, tan4(32'h3F80_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 0, tan4(32'h7FC0_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 0, tan4(32'h7FC0_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 0, tan4(32'h4000_0000, 32'h0, 32'h0, 32'hBF80_0000));
    queue_corner(1'b0, 0, tan4(32'h3F80_0000, 32'h8000_0000, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 0, tan4(32'h7FC0_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 4095, tan4('1, '1, '1, '1));
    queue_corner(1'b0, 4095, tan4('1, '1, '1, '1));
    queue_corner(1'b0, 4095, tan4(32'h7F80_0000, 32'hFF80_0000, 32'h1, 32'h8000_0001));
    queue_corner(1'b0, 4095, tan4(32'h7F80_0000, 32'hFF80_0000, 32'h1, 32'h8000_0001));
    queue_corner(1'b0, 4095, tan4(32'h7F80_0000, 32'hFF80_0000, 32'h8000_0001, 32'h1));
    queue_corner(1'b1, 4095, tan4(32'h3F80_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 2048, tan4(32'h3F80_0000, 32'h0, 32'h0, 32'h3F80_0000));
    queue_corner(1'b0, 2048, tan4(32'h0, 32'h3F80_0000, 32'h0, 32'hBF80_0000));
    queue_corner(1'b0, 1365, tan4(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    queue_corner(1'b0, 2730, tan4(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    wait_drained();

    // Random phases over several vertex counts; every phase starts a mesh,
    // and the sender drains fully before each register write.
    write_vertex_count(13'd0);
    run_mixed(250);
    wait_drained();
    write_vertex_count(13'd1);
    run_mixed(250);
    wait_drained();
    steady = 1'b1;
    write_vertex_count(CountW'($urandom_range(4096)));
    run_mixed(250);
    wait_drained();
    steady = 1'b0;
    write_vertex_count(13'd4096);
    run_mixed(282);
    wait_drained();

    // Let any stray result beat show up before the verdict.
    repeat (20) @(posedge clk_i);
    if ((fault_count == 0) && (index_forecast.size() == 0)) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, mesh clears included.
  initial begin
    #8ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
